// ===== src/gbi_pkg.sv =====
// ---------------------------------------------------------------------------
// gbi_pkg: shared types and constants of the GF(2) basis insertion block
// Command and result payloads, action codes and the per-stage control word
// that travels down the chain of pivot cells.
// ---------------------------------------------------------------------------
package gbi_pkg;

    localparam int BOND_MAX = 64;
    localparam int RANK_W   = 7;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    typedef struct packed {
        logic                action;
        logic [BOND_MAX-1:0] bonds;
    } t_gbi_cmd;

    typedef struct packed {
        logic              independent;
        logic [RANK_W-1:0] rank;
    } t_gbi_res;

    // Control word handed from one pivot cell to the next.
    typedef struct packed {
        logic act;  // a vector is in this stage
        logic clm;  // some higher cell has already claimed the new row
    } t_gbi_ctl;

endpackage

// ===== src/gbi_cell.sv =====
// ---------------------------------------------------------------------------
// gbi_cell: one pivot cell of the echelon basis chain
// Holds the basis row whose pivot is POS, reduces the passing vector with it
// and registers the result for the next lower cell. The first cell that sees
// its pivot bit set with no row stored claims the slot for the final vector.
// ---------------------------------------------------------------------------
module gbi_cell #(
    parameter int BOND_BITS = gbi_pkg::BOND_MAX,
    parameter int POS       = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gbi_pkg::t_gbi_ctl    i_ctl,
    input  logic [BOND_BITS-1:0] i_vec,
    input  logic                 i_commit,
    input  logic [BOND_BITS-1:0] i_row,
    input  logic                 i_clear,
    output gbi_pkg::t_gbi_ctl    o_ctl,
    output logic [BOND_BITS-1:0] o_vec
);

    logic [BOND_BITS-1:0] r_row;
    logic                 r_valid;
    logic                 r_claim;
    gbi_pkg::t_gbi_ctl    r_ctl;
    logic [BOND_BITS-1:0] r_vec;

    logic                 w_hit;
    logic                 w_take;
    gbi_pkg::t_gbi_ctl    n_ctl;
    logic [BOND_BITS-1:0] n_vec;
    logic                 n_claim;

    always_comb begin
        w_hit  = i_ctl.act && i_vec[POS];
        w_take = w_hit && !r_valid && !i_ctl.clm;
        n_vec  = (w_hit && r_valid) ? (i_vec ^ r_row) : i_vec;
        n_ctl.act = i_ctl.act;
        n_ctl.clm = i_ctl.clm || w_take;
        if (i_ctl.act) begin
            n_claim = w_take;
        end else if (i_commit) begin
            n_claim = 1'b0;
        end else begin
            n_claim = r_claim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_claim <= 1'b0;
            r_ctl   <= '0;
        end else begin
            r_ctl   <= n_ctl;
            r_claim <= n_claim;
            // A clear taken in the same cycle as a commit comes later in order.
            if (i_clear) begin
                r_valid <= 1'b0;
            end else if (i_commit && r_claim) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
        if (i_commit && r_claim) begin
            r_row <= i_row;
        end
    end

    assign o_ctl = r_ctl;
    assign o_vec = r_vec;

endmodule

// ===== src/gf2_basis_insert.sv =====
// ---------------------------------------------------------------------------
// gf2_basis_insert: incremental echelon basis over GF(2) of bond masks
// An insert reduces its mask through a chain of pivot cells, highest pivot
// first; a mask that stays non-zero is stored under its top bit.
// ---------------------------------------------------------------------------
//  Channel   Ports                       Transfer
//  --------  --------------------------  ---------------------------------
//  command   start, busy, i_cmd          edge with start high, busy low
//  result    o_valid, o_res              every cycle o_valid is high
//
//  An insert passes one pivot cell per cycle: its result appears once it
//  has gone through the input register and the chain, and busy drops in
//  that result cycle, so the next insert can be accepted in the result cycle.
//  A clear answers in the cycle after its transfer and leaves busy low.
//  Synchronous active-low reset empties the basis. Results cannot be stalled.
// ---------------------------------------------------------------------------
module gf2_basis_insert #(
    parameter int BOND_BITS = gbi_pkg::BOND_MAX
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  gbi_pkg::t_gbi_cmd i_cmd,
    output logic              o_valid,
    output gbi_pkg::t_gbi_res o_res
);

    localparam int CW = $clog2(BOND_BITS + 1);

    logic                 r_busy;
    logic                 r_clr;
    logic                 r_in_act;
    logic [BOND_BITS-1:0] r_in_vec;
    logic [CW-1:0]        r_count;

    gbi_pkg::t_gbi_ctl    s_ctl [0:BOND_BITS];
    logic [BOND_BITS-1:0] s_vec [0:BOND_BITS];
    logic [BOND_BITS-1:0] w_acts;

    logic                 w_accept;
    logic                 w_insert;
    logic                 w_clear;
    logic                 w_done;
    logic                 w_indep;
    logic [CW:0]          w_rank_sum;

    assign w_done   = s_ctl[0].act;
    assign busy     = r_busy && !w_done;
    assign w_accept = start && !busy;
    assign w_insert = w_accept && (i_cmd.action == gbi_pkg::ACT_INSERT);
    assign w_clear  = w_accept && (i_cmd.action == gbi_pkg::ACT_CLEAR);
    assign w_indep  = w_done && s_ctl[0].clm;
    assign w_rank_sum = {1'b0, r_count} + (CW + 1)'(w_indep);

    assign s_ctl[BOND_BITS].act = r_in_act;
    assign s_ctl[BOND_BITS].clm = 1'b0;
    assign s_vec[BOND_BITS]     = r_in_vec;

    genvar p;
    generate
        for (p = 0; p < BOND_BITS; p++) begin : g_cell
            gbi_cell #(
                .BOND_BITS (BOND_BITS),
                .POS       (p)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (s_ctl[p+1]),
                .i_vec    (s_vec[p+1]),
                .i_commit (w_done),
                .i_row    (s_vec[0]),
                .i_clear  (w_clear),
                .o_ctl    (s_ctl[p]),
                .o_vec    (s_vec[p])
            );
            assign w_acts[p] = s_ctl[p].act;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_clr    <= 1'b0;
            r_in_act <= 1'b0;
            r_count  <= '0;
        end else begin
            r_in_act <= w_insert;
            r_clr    <= w_clear;
            if (w_insert) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            if (w_clear) begin
                r_count <= '0;
            end else begin
                r_count <= w_rank_sum[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_insert) begin
            r_in_vec <= i_cmd.bonds[BOND_BITS-1:0];
        end
    end

    assign o_valid           = w_done || r_clr;
    assign o_res.independent = w_indep;
    assign o_res.rank        = gbi_pkg::RANK_W'(w_rank_sum);

    // At most one vector is in the chain at any time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_acts, r_in_act}))
        else $error("more than one vector in the pivot chain");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while the block still reports busy");

    a_rank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_count} <= (CW + 1)'(BOND_BITS)))
        else $error("rank exceeds the number of pivots");

    a_insert_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_insert |=> (busy && !o_valid))
        else $error("insert did not hold the block busy");

endmodule

// ===== tb/sv/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench: regression for the GF(2) basis insertion block
// Inserts and clears bond masks through the command port and follows the
// echelon basis in a model of its own. Each result strobe is compared field
// by field with the oldest predicted outcome. Sender gaps vary by phase.
// ---------------------------------------------------------------------------
module testbench;

    localparam int BOND_MAX    = gbi_pkg::BOND_MAX;
    localparam int BOND_BITS   = BOND_MAX;
    localparam int ITEM_TARGET = 1700;
    localparam logic [BOND_MAX-1:0] BOND_KEEP = {BOND_MAX{1'b1}} >> (BOND_MAX - BOND_BITS);

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    gbi_pkg::t_gbi_cmd i_cmd   = '0;
    logic              o_valid;
    gbi_pkg::t_gbi_res o_res;

    // Predicted basis contents, one row per pivot.
    logic [BOND_MAX-1:0]        basis_row [BOND_MAX];
    logic [BOND_MAX-1:0]        pivot_held = '0;
    logic [gbi_pkg::RANK_W-1:0] basis_rank = '0;

    gbi_pkg::t_gbi_cmd cmd_backlog[$];
    gbi_pkg::t_gbi_res awaited_outcomes[$];
    int                accepted_count = 0;
    int                mismatch_count = 0;
    int                directed_count = 0;

    gbi_pkg::t_gbi_cmd next_cmd;
    logic              next_start;

    gf2_basis_insert #(
        .BOND_BITS (BOND_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [BOND_MAX-1:0] wide_random();
        return {$urandom, $urandom};
    endfunction

    // Reduces the mask against the held rows, highest pivot first, and stores
    // whatever remains under its leading bit.
    function automatic gbi_pkg::t_gbi_res reduce_and_store(input gbi_pkg::t_gbi_cmd cmd);
        gbi_pkg::t_gbi_res   res;
        logic [BOND_MAX-1:0] vec;
        int                  lead;
        res = '0;
        if (cmd.action == gbi_pkg::ACT_CLEAR) begin
            for (int p = 0; p < BOND_MAX; p++) basis_row[p] = '0;
            pivot_held = '0;
            basis_rank = '0;
            return res;
        end
        vec = cmd.bonds & BOND_KEEP;
        for (int p = BOND_BITS - 1; p >= 0; p--) begin
            if (vec[p] && pivot_held[p]) vec ^= basis_row[p];
        end
        if (vec != '0) begin
            lead = 0;
            for (int p = 0; p < BOND_MAX; p++) begin
                if (vec[p]) lead = p;
            end
            basis_row[lead]  = vec;
            pivot_held[lead] = 1'b1;
            basis_rank       = basis_rank + 1'b1;
            res.independent  = 1'b1;
        end
        res.rank = basis_rank;
        return res;
    endfunction

    // Sender idling by phase: dense stretches alternate with sparse ones.
    function automatic int sender_idle_pct(input int done);
        int share;
        share = done * 5 / (ITEM_TARGET + directed_count);
        case (share)
            0: begin
                return 0;
            end
            1: begin
                return 76;
            end
            2: begin
                return 0;
            end
            3: begin
                return 16;
            end
            default: begin
                return 76;
            end
        endcase
    endfunction

    task automatic queue_item(input logic action, input logic [BOND_MAX-1:0] mask);
        gbi_pkg::t_gbi_cmd c;
        c.action = action;
        c.bonds  = mask;
        cmd_backlog.insert(cmd_backlog.size(), c);
    endtask

    task automatic note_mismatch(input string what, input gbi_pkg::t_gbi_res want,
                                 input gbi_pkg::t_gbi_res got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch (%s): expected independent=%0d rank=%0d, %s%0d rank=%0d",
                     what, want.independent, want.rank, "got independent=",
                     got.independent, got.rank);
        end
    endtask

    // Driver: a command is held until the transfer, then the next one is
    // offered at once or after a random gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            next_start = start;
            next_cmd   = i_cmd;
            if (start && !busy) begin
                awaited_outcomes.insert(awaited_outcomes.size(), reduce_and_store(i_cmd));
                accepted_count++;
                next_start = 1'b0;
            end
            if (!next_start && cmd_backlog.size() != 0 &&
                $urandom_range(99, 0) >= sender_idle_pct(accepted_count)) begin
                next_cmd   = cmd_backlog.pop_front();
                next_start = 1'b1;
            end
            start <= next_start;
            i_cmd <= next_cmd;
        end
    end

    // Monitor: every strobe is a transfer and must match the oldest outcome.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (awaited_outcomes.size() == 0) begin
                note_mismatch("no result awaited", '0, o_res);
            end else if (o_res.independent !== awaited_outcomes[0].independent ||
                         o_res.rank !== awaited_outcomes[0].rank) begin
                note_mismatch("wrong field", awaited_outcomes.pop_front(), o_res);
            end else begin
                void'(awaited_outcomes.pop_front());
            end
        end
    end

    initial begin
        logic [BOND_MAX-1:0] m;
        logic [BOND_MAX-1:0] kept[$];
        int                  style;
        int                  run_len;
        int                  w;

        for (int p = 0; p < BOND_MAX; p++) basis_row[p] = '0;

        // Directed part: zero masks, extreme bits, reduction to zero and clears.
        queue_item(gbi_pkg::ACT_INSERT, '0);
        queue_item(gbi_pkg::ACT_INSERT, '1);
        queue_item(gbi_pkg::ACT_INSERT, '1);
        queue_item(gbi_pkg::ACT_INSERT, 64'd1);
        queue_item(gbi_pkg::ACT_INSERT, 64'h8000_0000_0000_0000);
        queue_item(gbi_pkg::ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFE);
        queue_item(gbi_pkg::ACT_INSERT, 64'h5555_5555_5555_5555);
        queue_item(gbi_pkg::ACT_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_item(gbi_pkg::ACT_INSERT, 64'hFFFF_FFFF_0000_0000);
        queue_item(gbi_pkg::ACT_INSERT, 64'h0000_0000_8000_0000);
        queue_item(gbi_pkg::ACT_INSERT, 64'h0123_4567_89AB_CDEF);
        queue_item(gbi_pkg::ACT_CLEAR,  '1);
        queue_item(gbi_pkg::ACT_INSERT, '0);
        queue_item(gbi_pkg::ACT_CLEAR,  '0);
        queue_item(gbi_pkg::ACT_INSERT, 64'h8000_0000_0000_0000);
        queue_item(gbi_pkg::ACT_INSERT, 64'h8000_0000_0000_0001);
        queue_item(gbi_pkg::ACT_INSERT, 64'd1);
        queue_item(gbi_pkg::ACT_INSERT, 64'h0000_0000_0000_0006);
        queue_item(gbi_pkg::ACT_INSERT, 64'h0000_0000_0000_0003);
        queue_item(gbi_pkg::ACT_INSERT, 64'h0000_0000_0000_0005);
        queue_item(gbi_pkg::ACT_CLEAR,  64'h0123_4567_89AB_CDEF);
        directed_count = cmd_backlog.size();

        // Random part: episodes that start from an empty basis and often run
        // long enough to fill all pivots, with clears and zero masks as noise.
        while (cmd_backlog.size() < directed_count + ITEM_TARGET) begin
            queue_item(gbi_pkg::ACT_CLEAR, wide_random());
            kept.delete();
            style   = $urandom_range(4, 0);
            run_len = ($urandom_range(2, 0) == 0) ? $urandom_range(20, 1)
                                                  : $urandom_range(100, 60);
            repeat (run_len) begin
                if ($urandom_range(24, 0) == 0) begin
                    if ($urandom_range(1, 0) == 0) begin
                        queue_item(gbi_pkg::ACT_CLEAR, wide_random());
                        kept.delete();
                    end else begin
                        queue_item(gbi_pkg::ACT_INSERT, '0);
                    end
                end else begin
                    m = wide_random();
                    case (style)
                        1: begin
                            m = '0;
                            repeat ($urandom_range(3, 1)) begin
                                m[$urandom_range(BOND_MAX - 1, 0)] = 1'b1;
                            end
                        end
                        2: begin
                            w = $urandom_range(16, 3);
                            m = (m & ((64'd1 << w) - 1)) << $urandom_range(BOND_MAX - w, 0);
                        end
                        3: begin
                            m = 64'd1 << $urandom_range(BOND_MAX - 1, 0);
                        end
                        4: begin
                            // Sums of earlier rows should come back dependent.
                            if (kept.size() >= 3 && $urandom_range(1, 0) == 0) begin
                                m = kept[$urandom_range(kept.size() - 1, 0)] ^
                                    kept[$urandom_range(kept.size() - 1, 0)];
                                if ($urandom_range(1, 0) == 0) begin
                                    m ^= kept[$urandom_range(kept.size() - 1, 0)];
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    queue_item(gbi_pkg::ACT_INSERT, m);
                    kept.insert(kept.size(), m);
                end
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || start || awaited_outcomes.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (BOND_BITS + 8) @(negedge i_clk);

        if (mismatch_count == 0 && awaited_outcomes.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
